// ===== hw/rtl/csd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csd_pkg;

	// definition table size
	localparam int SIGNAL_SLOTS = 32;
	localparam int SLOT_W = (SIGNAL_SLOTS > 1) ? $clog2(SIGNAL_SLOTS) : 1;
	localparam int CNT_W = $clog2(SIGNAL_SLOTS + 1);

	// serial multiplier: raw magnitude consumed one digit per cycle
	localparam int DIGIT_W = 8;
	localparam int NUM_DIGITS = 64 / DIGIT_W;
	localparam int DCNT_W = $clog2(NUM_DIGITS);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_DECODE = 1'b1;

	localparam logic [63:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] VALUE_MIN = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic               func;
		logic [28:0]        frame_id;
		logic [63:0]        payload;
		logic [4:0]         slot;
		logic [5:0]         start_bit;
		logic [6:0]         bit_length;
		logic               is_signed;
		logic signed [31:0] factor;
		logic signed [31:0] offset;
		logic               entry_valid;
	} in_word_t;

	typedef struct packed {
		logic               found;
		logic [4:0]         signal_slot;
		logic signed [63:0] value;
		logic               saturated;
		logic               last;
	} out_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/can_signal_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// CAN signal decoder. A write word (func = 0) stores one signal definition
// (message id, start bit, length, signedness, Q16.16 factor and offset) in the
// slot it names and is taken with no result, leaving input ready. A decode word
// (func = 1) is compared against every slot; each valid slot with a matching
// id yields one result in slot order, value = raw * factor + offset in Q48.16,
// clipped to the signed 64-bit range with saturated set. The last result of a
// frame carries last; a frame that matches nothing yields one not-found result
// with all fields zero and last set. A decode word costs one id-table pass
// (one id memory read per cycle), then for each matching slot a slot pick
// with definition read, field shift, sign and magnitude, an 8-bit by 32-bit
// serial multiply and a final add and clip, or a pick and the not-found step
// for a not-found result. Input is taken again once the
// last result is in the output register; that register holds one result, so
// a stalled consumer stalls the walk. Valid flags are flip-flops cleared by
// reset, so the block needs no clearing pass and is ready right after reset.
module can_signal_decoder (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire csd_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  wire                 out_ready,
	output csd_pkg::out_word_t  out_word
);
	import csd_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_PICK  = 3'd2;
	localparam logic [2:0] ST_FETCH = 3'd3;
	localparam logic [2:0] ST_EXTR  = 3'd4;
	localparam logic [2:0] ST_MUL   = 3'd5;
	localparam logic [2:0] ST_ADD   = 3'd6;
	localparam logic [2:0] ST_EMPTY = 3'd7;

	// layout, factor and offset of one slot, kept in one memory row
	typedef struct packed {
		logic        is_signed;
		logic [5:0]  start_bit;
		logic [6:0]  bit_length;
		logic [31:0] factor;
		logic [31:0] offset;
	} def_t;

	logic [2:0]              state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [DCNT_W-1:0]       dig_q;
	logic [SIGNAL_SLOTS-1:0] vld_q;
	logic [SIGNAL_SLOTS-1:0] mask_q;
	logic                    out_valid_q;

	// definition storage (ids and rows are undefined until written)
	logic [28:0] ids [SIGNAL_SLOTS];
	def_t        defs [SIGNAL_SLOTS];

	logic [28:0]       id_q;
	logic [28:0]       id_rd_q;
	logic [63:0]       pay_q;
	def_t              def_rd_q;
	logic [SLOT_W-1:0] cur_q;
	logic              last_q;
	logic [63:0]       shl_q;
	logic [63:0]       raw_q;
	logic              neg_q;
	logic              carry_q;
	logic [31:0]       fmag_q;
	logic [32:0]       acc_q;
	logic [63:0]       lo_q;
	out_word_t         out_q;

	logic              in_acc;
	logic              wr_acc;
	logic              dec_acc;
	logic              wr_ok;
	logic [SLOT_W-1:0] wr_idx;
	logic [CNT_W-1:0]  cnt_prev;
	logic [SLOT_W-1:0] prev_idx;
	logic [SLOT_W-1:0] rd_idx;
	logic              id_hit;
	logic              scan_done;
	logic [SLOT_W-1:0] pick_idx;
	logic [SIGNAL_SLOTS-1:0] rest;
	logic [6:0]        len_c;
	logic [5:0]        rsh;
	logic [63:0]       field;
	logic [63:0]       raw_c;
	logic              neg_c;
	logic [31:0]       fmag_c;
	logic [7:0]        dig_in;
	logic [8:0]        dsum;
	logic [39:0]       part;
	logic [40:0]       t;
	logic              pneg;
	logic [97:0]       prod_ext;
	logic [97:0]       off_ext;
	logic [97:0]       sum;
	logic              fits;
	logic              out_free;
	logic              load;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign wr_acc    = in_acc && (in_word.func == FUNC_WRITE);
	assign dec_acc   = in_acc && (in_word.func == FUNC_DECODE);
	assign wr_ok     = int'(in_word.slot) < SIGNAL_SLOTS;
	assign wr_idx    = SLOT_W'(in_word.slot);

	// id scan: read slot cnt, compare slot cnt-1 whose id was read the cycle before
	assign cnt_prev  = cnt_q - 1'b1;
	assign prev_idx  = cnt_prev[SLOT_W-1:0];
	assign rd_idx    = cnt_q[SLOT_W-1:0];
	assign id_hit    = vld_q[prev_idx] && (id_rd_q == id_q);
	assign scan_done = (cnt_q == CNT_W'(SIGNAL_SLOTS));

	// lowest pending match
	always_comb begin
		pick_idx = '0;
		for (int i = SIGNAL_SLOTS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick_idx = SLOT_W'(i);
			end
		end
		rest = mask_q;
		rest[pick_idx] = 1'b0;
	end

	// field extraction: MSB-aligned word shifted down by 64 - length
	assign len_c  = (def_rd_q.bit_length > 7'd64) ? 7'd64 : def_rd_q.bit_length;
	assign rsh    = 6'(7'd64 - len_c);
	assign field  = def_rd_q.is_signed ? 64'($signed(shl_q) >>> rsh) : (shl_q >> rsh);
	assign raw_c  = (len_c == 7'd0) ? 64'd0 : field;
	assign neg_c  = def_rd_q.is_signed && (len_c != 7'd0) && shl_q[63];
	assign fmag_c = def_rd_q.factor[31] ? (~def_rd_q.factor + 32'd1) : def_rd_q.factor;

	// one digit per cycle; negation of a raw value is folded in with a carry
	assign dig_in = neg_q ? ~raw_q[DIGIT_W-1:0] : raw_q[DIGIT_W-1:0];
	assign dsum   = {1'b0, dig_in} + {8'd0, carry_q};
	assign part   = 40'(dsum[7:0]) * 40'(fmag_q);
	assign t      = 41'(acc_q) + 41'(part);

	// signed product plus offset, then clip
	assign pneg     = neg_q ^ def_rd_q.factor[31];
	assign prod_ext = {1'b0, acc_q, lo_q};
	assign off_ext  = 98'($signed(def_rd_q.offset));
	assign sum      = off_ext + (pneg ? ~prod_ext : prod_ext) + 98'(pneg);
	assign fits     = (&sum[97:63]) || !(|sum[97:63]);

	assign out_free = !out_valid_q || out_ready;
	assign load     = ((state_q == ST_ADD) || (state_q == ST_EMPTY)) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			dig_q       <= '0;
			vld_q       <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (wr_acc && wr_ok) begin
						vld_q[wr_idx] <= in_word.entry_valid;
					end
					if (dec_acc) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q != '0) begin
						mask_q[prev_idx] <= id_hit;
					end
					if (scan_done) begin
						state_q <= ST_PICK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_PICK: begin
					if (mask_q == '0) begin
						state_q <= ST_EMPTY;
					end else begin
						mask_q[pick_idx] <= 1'b0;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_EXTR;
				end
				ST_EXTR: begin
					dig_q   <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					dig_q <= dig_q + 1'b1;
					if (dig_q == DCNT_W'(NUM_DIGITS - 1)) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (out_free) begin
						state_q <= last_q ? ST_IDLE : ST_PICK;
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// definition memories
	always_ff @(posedge clk) begin
		if (wr_acc && wr_ok) begin
			ids[wr_idx]  <= in_word.frame_id;
			defs[wr_idx] <= '{is_signed:  in_word.is_signed,
			                  start_bit:  in_word.start_bit,
			                  bit_length: in_word.bit_length,
			                  factor:     in_word.factor,
			                  offset:     in_word.offset};
		end
		id_rd_q <= ids[rd_idx];
		if (state_q == ST_PICK) begin
			def_rd_q <= defs[pick_idx];
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (dec_acc) begin
			id_q  <= in_word.frame_id;
			pay_q <= in_word.payload;
		end
		if (state_q == ST_PICK) begin
			cur_q  <= pick_idx;
			last_q <= (rest == '0);
		end
		if (state_q == ST_FETCH) begin
			shl_q <= pay_q << def_rd_q.start_bit;
		end
		if (state_q == ST_EXTR) begin
			raw_q   <= raw_c;
			neg_q   <= neg_c;
			carry_q <= neg_c;
			fmag_q  <= fmag_c;
			acc_q   <= '0;
		end
		if (state_q == ST_MUL) begin
			raw_q   <= raw_q >> DIGIT_W;
			carry_q <= dsum[8];
			lo_q    <= {t[7:0], lo_q[63:DIGIT_W]};
			acc_q   <= t[40:8];
		end
		if (load) begin
			if (state_q == ST_ADD) begin
				out_q.found       <= 1'b1;
				out_q.signal_slot <= 5'(cur_q);
				out_q.value       <= fits ? sum[63:0] : (sum[97] ? VALUE_MIN : VALUE_MAX);
				out_q.saturated   <= !fits;
				out_q.last        <= last_q;
			end else begin
				out_q.found       <= 1'b0;
				out_q.signal_slot <= 5'd0;
				out_q.value       <= 64'd0;
				out_q.saturated   <= 1'b0;
				out_q.last        <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/csd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csd_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_ready,
	input wire csd_pkg::in_word_t  in_word,
	input wire                 out_valid,
	input wire                 out_ready,
	input wire csd_pkg::out_word_t out_word
);
	import csd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result changed while stalled");

	// a decode word blocks input until its results are produced
	a_dec_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_word.func == FUNC_DECODE) |=> !in_ready)
		else $error("input taken during decode");

	// a write word leaves the block ready
	a_wr_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_word.func == FUNC_WRITE) |=> in_ready)
		else $error("write word stalled input");

	// not-found result is all zero and closes the frame
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.found |-> out_word.last && (out_word.signal_slot == 5'd0)
		&& (out_word.value == 64'sd0) && !out_word.saturated)
		else $error("malformed not-found result");

	// clipping gives one of the range ends
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.saturated |->
		(out_word.value == VALUE_MAX) || (out_word.value == VALUE_MIN))
		else $error("saturated value off range end");

endmodule

bind can_signal_decoder csd_checker u_csd_checker (.*);

`default_nettype wire
